[rtl/core/rtq_pkg.sv]
// Shared types and constants for the range trust qualifier.
// Holds the event codes, register indexes, reset values and the word structs.
// No dependencies; rtq_cfg, rtq_state and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package rtq_pkg;

    // Event codes carried in the operation field.
    typedef enum logic [1:0] {
        OP_EVIDENCE = 2'd0,
        OP_RANGE    = 2'd1,
        OP_RESET    = 2'd2
    } op_t;

    // Configuration port geometry.
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_NEG_TOL  = 3'd0;
    localparam logic [2:0] REG_MAX_CM   = 3'd1;
    localparam logic [2:0] REG_SPREAD   = 3'd2;
    localparam logic [2:0] REG_WINDOW   = 3'd3;
    localparam logic [2:0] REG_QTHRESH  = 3'd4;

    // Register reset values.
    localparam logic [15:0]        RST_NEG_TOL = 16'd50;
    localparam logic [30:0]        RST_MAX_CM  = 31'd3000;
    localparam logic [15:0]        RST_SPREAD  = 16'd30;
    localparam logic [7:0]         RST_WINDOW  = 8'd3;
    localparam logic signed [15:0] RST_QTHRESH = 16'sd0;

    // Configuration register set.
    typedef struct packed {
        logic [15:0]        neg_tol;
        logic [30:0]        max_cm;
        logic [15:0]        spread;
        logic [7:0]         window;
        logic signed [15:0] q_thresh;
    } cfg_t;

    // One input word.
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] range_cm;
        logic [31:0]        block_index;
        logic               verdict_ok;
        logic signed [15:0] ts_quality;
    } item_t;

    // One result word.
    typedef struct packed {
        logic               accepted;
        logic               have_range;
        logic [30:0]        latched_cm;
        logic [31:0]        latched_block;
        logic [7:0]         agree_level;
        logic               trusted;
        logic               evidence_ok;
        logic signed [15:0] worst_quality;
        logic [31:0]        generation;
    } result_t;

endpackage

[rtl/core/rtq_in_if.sv]
// Input channel of the range trust qualifier: valid/ready plus the event fields.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface rtq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] range_cm;
    logic [31:0]        block_index;
    logic               verdict_ok;
    logic signed [15:0] ts_quality;

    modport source (
        output valid, operation, range_cm, block_index, verdict_ok, ts_quality,
        input  ready
    );

    modport sink (
        input  valid, operation, range_cm, block_index, verdict_ok, ts_quality,
        output ready
    );
endinterface

[rtl/core/rtq_out_if.sv]
// Result channel of the range trust qualifier: valid/ready plus the result fields.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface rtq_out_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               have_range;
    logic [30:0]        latched_cm;
    logic [31:0]        latched_block;
    logic [7:0]         agree_level;
    logic               trusted;
    logic               evidence_ok;
    logic signed [15:0] worst_quality;
    logic [31:0]        generation;

    modport source (
        output valid, accepted, have_range, latched_cm, latched_block, agree_level,
               trusted, evidence_ok, worst_quality, generation,
        input  ready
    );

    modport sink (
        input  valid, accepted, have_range, latched_cm, latched_block, agree_level,
               trusted, evidence_ok, worst_quality, generation,
        output ready
    );
endinterface

[rtl/core/rtq_cfg.sv]
// APB-style configuration registers of the range trust qualifier.
// Depends on rtq_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module rtq_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtq_pkg::ADDR_W-1:0]  paddr,
    input  logic [rtq_pkg::DATA_W-1:0]  pwdata,
    output logic [rtq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output rtq_pkg::cfg_t               cfg
);

    rtq_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[rtq_pkg::ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neg_tol  <= rtq_pkg::RST_NEG_TOL;
            cfg_reg.max_cm   <= rtq_pkg::RST_MAX_CM;
            cfg_reg.spread   <= rtq_pkg::RST_SPREAD;
            cfg_reg.window   <= rtq_pkg::RST_WINDOW;
            cfg_reg.q_thresh <= rtq_pkg::RST_QTHRESH;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                rtq_pkg::REG_NEG_TOL: cfg_reg.neg_tol  <= pwdata[15:0];
                rtq_pkg::REG_MAX_CM:  cfg_reg.max_cm   <= pwdata[30:0];
                rtq_pkg::REG_SPREAD:  cfg_reg.spread   <= pwdata[15:0];
                rtq_pkg::REG_WINDOW:  cfg_reg.window   <= pwdata[7:0];
                rtq_pkg::REG_QTHRESH: cfg_reg.q_thresh <= $signed(pwdata[15:0]);
                default:              ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_idx)
            rtq_pkg::REG_NEG_TOL: prdata = {16'd0, cfg_reg.neg_tol};
            rtq_pkg::REG_MAX_CM:  prdata = {1'b0, cfg_reg.max_cm};
            rtq_pkg::REG_SPREAD:  prdata = {16'd0, cfg_reg.spread};
            rtq_pkg::REG_WINDOW:  prdata = {24'd0, cfg_reg.window};
            rtq_pkg::REG_QTHRESH: prdata = {{16{cfg_reg.q_thresh[15]}}, cfg_reg.q_thresh};
            default:              prdata = '0;
        endcase
    end

endmodule

[rtl/core/rtq_state.sv]
// Qualifier state and its combinational update for one event word.
// Depends on rtq_pkg for item_t, result_t, cfg_t and the event codes.
`timescale 1ns / 1ps

module rtq_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rtq_pkg::item_t    item,
    input  rtq_pkg::cfg_t     cfg,
    output rtq_pkg::result_t  result
);

    logic               range_valid_reg,     range_valid_next;
    logic [30:0]        last_cm_reg,         last_cm_next;
    logic [31:0]        last_block_reg,      last_block_next;
    logic [7:0]         agree_run_reg,       agree_run_next;
    logic               pending_valid_reg,   pending_valid_next;
    logic               pending_ok_reg,      pending_ok_next;
    logic signed [15:0] pending_quality_reg, pending_quality_next;
    logic [7:0]         good_run_reg,        good_run_next;
    logic signed [15:0] quality_floor_reg,   quality_floor_next;
    logic [31:0]        latch_count_reg,     latch_count_next;
    logic               accepted_next;

    logic signed [32:0] cm_ext;
    logic signed [32:0] low_lim;
    logic signed [32:0] high_lim;
    logic               plausible;
    logic [30:0]        cm_clamped;
    logic [30:0]        delta;
    logic               agree;
    logic               ev_ok;
    logic signed [15:0] q_sel;
    logic [7:0]         good_mid;
    logic [31:0]        count_inc;

    // Plausibility window and clamp at zero.
    assign cm_ext     = {item.range_cm[31], item.range_cm};
    assign low_lim    = -$signed({17'd0, cfg.neg_tol});
    assign high_lim   = $signed({2'b00, cfg.max_cm});
    assign plausible  = (cm_ext >= low_lim) && (cm_ext <= high_lim);
    assign cm_clamped = item.range_cm[31] ? 31'd0 : item.range_cm[30:0];

    // Step size against the last latched range.
    assign delta = (cm_clamped >= last_cm_reg) ? (cm_clamped - last_cm_reg)
                                               : (last_cm_reg - cm_clamped);
    assign agree = range_valid_reg && (delta <= {15'd0, cfg.spread});

    // Pending evidence as seen by a range; missing evidence counts as failed.
    assign ev_ok    = pending_valid_reg && pending_ok_reg;
    assign q_sel    = pending_valid_reg ? pending_quality_reg : 16'sd0;
    assign good_mid = agree ? good_run_reg : 8'd0;

    // Generation count skips zero on wrap.
    assign count_inc = (latch_count_reg == 32'hFFFF_FFFF) ? 32'd1 : (latch_count_reg + 32'd1);

    // Next-state logic for one event.
    always_comb
    begin
        range_valid_next     = range_valid_reg;
        last_cm_next         = last_cm_reg;
        last_block_next      = last_block_reg;
        agree_run_next       = agree_run_reg;
        pending_valid_next   = pending_valid_reg;
        pending_ok_next      = pending_ok_reg;
        pending_quality_next = pending_quality_reg;
        good_run_next        = good_run_reg;
        quality_floor_next   = quality_floor_reg;
        latch_count_next     = latch_count_reg;
        accepted_next        = 1'b0;

        case (rtq_pkg::op_t'(item.operation))
            rtq_pkg::OP_EVIDENCE:
            begin
                pending_valid_next   = 1'b1;
                pending_ok_next      = item.verdict_ok && (item.ts_quality >= cfg.q_thresh);
                pending_quality_next = item.ts_quality;
            end
            rtq_pkg::OP_RANGE:
            begin
                pending_valid_next = 1'b0;
                if (!plausible)
                begin
                    agree_run_next = 8'd0;
                    good_run_next  = 8'd0;
                end
                else
                begin
                    accepted_next = 1'b1;
                    // Agreement run.
                    if (agree)
                    begin
                        if (agree_run_reg < cfg.window)
                        begin
                            agree_run_next = agree_run_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        agree_run_next = 8'd1;
                    end
                    // Good-evidence run and its worst quality.
                    if (!ev_ok)
                    begin
                        good_run_next      = 8'd0;
                        quality_floor_next = q_sel;
                    end
                    else
                    begin
                        good_run_next = good_mid;
                        if ((good_mid == 8'd0) || (q_sel < quality_floor_reg))
                        begin
                            quality_floor_next = q_sel;
                        end
                        if (good_mid < cfg.window)
                        begin
                            good_run_next = good_mid + 8'd1;
                        end
                    end
                    range_valid_next = 1'b1;
                    last_cm_next     = cm_clamped;
                    last_block_next  = item.block_index;
                    latch_count_next = count_inc;
                end
            end
            rtq_pkg::OP_RESET:
            begin
                range_valid_next   = 1'b0;
                agree_run_next     = 8'd0;
                pending_valid_next = 1'b0;
                good_run_next      = 8'd0;
                quality_floor_next = 16'sd0;
            end
            default:
            begin
            end
        endcase
    end

    // Result word reflects the state after the event.
    always_comb
    begin
        result.accepted      = accepted_next;
        result.have_range    = range_valid_next;
        result.latched_cm    = last_cm_next;
        result.latched_block = last_block_next;
        result.agree_level   = agree_run_next;
        result.trusted       = agree_run_next >= cfg.window;
        result.evidence_ok   = good_run_next >= cfg.window;
        result.worst_quality = quality_floor_next;
        result.generation    = latch_count_next;
    end

    // State registers, updated when an event leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_valid_reg     <= 1'b0;
            last_cm_reg         <= '0;
            last_block_reg      <= '0;
            agree_run_reg       <= '0;
            pending_valid_reg   <= 1'b0;
            pending_ok_reg      <= 1'b0;
            pending_quality_reg <= '0;
            good_run_reg        <= '0;
            quality_floor_reg   <= '0;
            latch_count_reg     <= '0;
        end
        else if (step)
        begin
            range_valid_reg     <= range_valid_next;
            last_cm_reg         <= last_cm_next;
            last_block_reg      <= last_block_next;
            agree_run_reg       <= agree_run_next;
            pending_valid_reg   <= pending_valid_next;
            pending_ok_reg      <= pending_ok_next;
            pending_quality_reg <= pending_quality_next;
            good_run_reg        <= good_run_next;
            quality_floor_reg   <= quality_floor_next;
            latch_count_reg     <= latch_count_next;
        end
    end

endmodule

[rtl/core/range_trust_qualifier.sv]
// Range trust qualifier top level. A word moves from the input register, through the
// qualifier logic, into the result register when that one is free. Throughput: one
// word per cycle while the result side takes words; the state update is one pass of
// compare and saturating-counter logic between the two registers.
// Reset (rst_n, asynchronous, active low) clears all qualifier state and loads the
// register defaults; the block is ready for words as soon as reset is released.
`timescale 1ns / 1ps

module range_trust_qualifier (
    input  logic                        clk,
    input  logic                        rst_n,
    rtq_in_if.sink                      evt,
    rtq_out_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtq_pkg::ADDR_W-1:0]  paddr,
    input  logic [rtq_pkg::DATA_W-1:0]  pwdata,
    output logic [rtq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    rtq_pkg::cfg_t    cfg;
    rtq_pkg::item_t   hold_reg;
    logic             hold_valid_reg, hold_valid_next;
    rtq_pkg::result_t res_reg;
    logic             res_valid_reg, res_valid_next;
    rtq_pkg::result_t result;
    logic             advance;
    logic             in_fire;

    rtq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtq_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (hold_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Handshake: a word moves into the result register when that register is free.
    assign advance   = hold_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !hold_valid_reg || advance;
    assign in_fire   = evt.valid && evt.ready;

    assign hold_valid_next = in_fire || (hold_valid_reg && !advance);
    assign res_valid_next  = advance || (res_valid_reg && !res.ready);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_reg.operation   <= evt.operation;
            hold_reg.range_cm    <= evt.range_cm;
            hold_reg.block_index <= evt.block_index;
            hold_reg.verdict_ok  <= evt.verdict_ok;
            hold_reg.ts_quality  <= evt.ts_quality;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.accepted      = res_reg.accepted;
    assign res.have_range    = res_reg.have_range;
    assign res.latched_cm    = res_reg.latched_cm;
    assign res.latched_block = res_reg.latched_block;
    assign res.agree_level   = res_reg.agree_level;
    assign res.trusted       = res_reg.trusted;
    assign res.evidence_ok   = res_reg.evidence_ok;
    assign res.worst_quality = res_reg.worst_quality;
    assign res.generation    = res_reg.generation;

endmodule

[verif/rtq_qualifier_checker.sv]
// Checker for the range trust qualifier: watches the event, result and register channels,
// predicts every result word and compares it field by field with what the block returns.
// Depends on rtq_pkg and the rtq_in_if / rtq_out_if interfaces.
`timescale 1ns / 1ps

module rtq_qualifier_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    rtq_in_if                           evt,
    rtq_out_if                          res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rtq_pkg::ADDR_W-1:0]  paddr,
    input  logic [rtq_pkg::DATA_W-1:0]  pwdata,
    output int                          words_owed,
    output int                          mismatches
);

    // Register copies, updated from the bus writes the checker observes.
    logic [15:0]        tol_neg;
    logic [30:0]        max_cm_lim;
    logic [15:0]        spread_lim;
    logic [7:0]         window_len;
    logic signed [15:0] q_min;

    // Qualifier state.
    logic               range_held;
    logic [30:0]        held_cm;
    logic [31:0]        held_block;
    logic [7:0]         agree_len;
    logic               ev_pending;
    logic               ev_good;
    logic signed [15:0] ev_quality;
    logic [7:0]         good_len;
    logic signed [15:0] floor_q;
    logic [31:0]        gen_count;

    // Predicted result words, oldest first.
    rtq_pkg::result_t reports_due[$];
    int               fail_count = 0;

    // Applies one event word to the state and returns the result word it should produce.
    function automatic rtq_pkg::result_t qualify_event(rtq_pkg::item_t w);
        rtq_pkg::result_t   r;
        logic               latched;
        logic               good;
        logic signed [15:0] q;
        logic signed [15:0] q_in;
        longint             cm;
        longint             prev;
        longint             delta;
        latched = 1'b0;
        q_in = w.ts_quality;
        case (w.operation)
            rtq_pkg::OP_EVIDENCE:
            begin
                ev_good = w.verdict_ok && (q_in >= q_min);
                ev_quality = q_in;
                ev_pending = 1'b1;
            end
            rtq_pkg::OP_RANGE:
            begin
                // Evidence is consumed by this range whether or not it is plausible.
                good = ev_pending && ev_good;
                q = ev_pending ? ev_quality : 16'sd0;
                ev_pending = 1'b0;
                cm = $signed(w.range_cm);
                if (cm < -longint'(tol_neg) || cm > longint'(max_cm_lim))
                begin
                    agree_len = 8'd0;
                    good_len = 8'd0;
                end
                else
                begin
                    if (cm < 0)
                    begin
                        cm = 0;
                    end
                    prev = longint'(held_cm);
                    delta = (cm >= prev) ? cm - prev : prev - cm;
                    if (range_held && delta <= longint'(spread_lim))
                    begin
                        if (agree_len < window_len)
                        begin
                            agree_len = agree_len + 8'd1;
                        end
                    end
                    else
                    begin
                        agree_len = 8'd1;
                        good_len = 8'd0;
                    end
                    if (!good)
                    begin
                        good_len = 8'd0;
                        floor_q = q;
                    end
                    else
                    begin
                        if (good_len == 8'd0 || q < floor_q)
                        begin
                            floor_q = q;
                        end
                        if (good_len < window_len)
                        begin
                            good_len = good_len + 8'd1;
                        end
                    end
                    range_held = 1'b1;
                    held_cm = cm[30:0];
                    held_block = w.block_index;
                    // The generation count skips zero when it wraps.
                    gen_count = gen_count + 32'd1;
                    if (gen_count == 32'd0)
                    begin
                        gen_count = 32'd1;
                    end
                    latched = 1'b1;
                end
            end
            rtq_pkg::OP_RESET:
            begin
                // The latched range and the generation count survive a range reset.
                range_held = 1'b0;
                agree_len = 8'd0;
                ev_pending = 1'b0;
                good_len = 8'd0;
                floor_q = 16'sd0;
            end
            default:
            begin
                // The unused code leaves the state alone.
            end
        endcase
        r.accepted = latched;
        r.have_range = range_held;
        r.latched_cm = held_cm;
        r.latched_block = held_block;
        r.agree_level = agree_len;
        r.trusted = (agree_len >= window_len);
        r.evidence_ok = (good_len >= window_len);
        r.worst_quality = floor_q;
        r.generation = gen_count;
        return r;
    endfunction

    task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_report(rtq_pkg::result_t want, rtq_pkg::result_t got);
        check_field("accepted", want.accepted, got.accepted);
        check_field("have_range", want.have_range, got.have_range);
        check_field("latched_cm", want.latched_cm, got.latched_cm);
        check_field("latched_block", want.latched_block, got.latched_block);
        check_field("agree_level", want.agree_level, got.agree_level);
        check_field("trusted", want.trusted, got.trusted);
        check_field("evidence_ok", want.evidence_ok, got.evidence_ok);
        check_field("worst_quality", want.worst_quality, got.worst_quality);
        check_field("generation", want.generation, got.generation);
    endtask

    // All channels are sampled at the rising edge; results are checked before new
    // events are predicted so that a word never meets its own prediction.
    always @(posedge clk)
    begin : watch
        rtq_pkg::item_t   w;
        rtq_pkg::result_t got;
        if (!rst_n)
        begin
            tol_neg = rtq_pkg::RST_NEG_TOL;
            max_cm_lim = rtq_pkg::RST_MAX_CM;
            spread_lim = rtq_pkg::RST_SPREAD;
            window_len = rtq_pkg::RST_WINDOW;
            q_min = rtq_pkg::RST_QTHRESH;
            range_held = 1'b0;
            held_cm = '0;
            held_block = '0;
            agree_len = '0;
            ev_pending = 1'b0;
            ev_good = 1'b0;
            ev_quality = '0;
            good_len = '0;
            floor_q = '0;
            gen_count = '0;
            reports_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    rtq_pkg::REG_NEG_TOL: tol_neg = pwdata[15:0];
                    rtq_pkg::REG_MAX_CM:  max_cm_lim = pwdata[30:0];
                    rtq_pkg::REG_SPREAD:  spread_lim = pwdata[15:0];
                    rtq_pkg::REG_WINDOW:  window_len = pwdata[7:0];
                    rtq_pkg::REG_QTHRESH: q_min = pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (res.valid && res.ready)
            begin
                got.accepted = res.accepted;
                got.have_range = res.have_range;
                got.latched_cm = res.latched_cm;
                got.latched_block = res.latched_block;
                got.agree_level = res.agree_level;
                got.trusted = res.trusted;
                got.evidence_ok = res.evidence_ok;
                got.worst_quality = res.worst_quality;
                got.generation = res.generation;
                if (reports_due.size() == 0)
                begin
                    $error("result word arrived with no event word outstanding");
                    fail_count++;
                end
                else
                begin
                    compare_report(reports_due.pop_front(), got);
                end
            end
            if (evt.valid && evt.ready)
            begin
                w.operation = evt.operation;
                w.range_cm = evt.range_cm;
                w.block_index = evt.block_index;
                w.verdict_ok = evt.verdict_ok;
                w.ts_quality = evt.ts_quality;
                reports_due.push_back(qualify_event(w));
            end
        end
        words_owed <= reports_due.size();
        mismatches <= fail_count;
    end

endmodule

[verif/tb_range_trust_qualifier.sv]
// Testbench top for the range trust qualifier: clock, reset, event and register stimulus,
// random back-pressure on the result channel, watchdog and final verdict.
// Depends on rtq_pkg, the channel interfaces, the block and rtq_qualifier_checker.
`timescale 1ns / 1ps

module tb_range_trust_qualifier;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 3000;
    localparam int         LONG_HOLD   = 300;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rtq_pkg::ADDR_W-1:0]  paddr;
    logic [rtq_pkg::DATA_W-1:0]  pwdata;
    logic [rtq_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    int                          words_owed;
    int                          mismatches;
    int                          quiet_cycles = 0;

    // Settings currently in the block, used to aim the ranges and qualities.
    logic [15:0]         cur_neg_tol  = rtq_pkg::RST_NEG_TOL;
    logic [30:0]         cur_max_cm   = rtq_pkg::RST_MAX_CM;
    logic [15:0]         cur_spread   = rtq_pkg::RST_SPREAD;
    logic signed [15:0]  cur_qthresh  = rtq_pkg::RST_QTHRESH;

    // Last plausible range sent; agreeing ranges are drawn around it.
    longint              near_cm = 0;
    int                  send_calm = 0;
    bit                  long_hold = 1'b0;

    rtq_in_if  evt_ch();
    rtq_out_if res_ch();

    range_trust_qualifier uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rtq_qualifier_checker qual_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt_ch),
        .res        (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .words_owed (words_owed),
        .mismatches (mismatches)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Wait before the next word: one time in ten a run of back-to-back words starts, else a random wait.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic rtq_pkg::item_t mk(logic [1:0] op, logic signed [31:0] cm,
                                          logic [31:0] blk, logic ok, logic signed [15:0] q);
        rtq_pkg::item_t w;
        w.operation = op;
        w.range_cm = cm;
        w.block_index = blk;
        w.verdict_ok = ok;
        w.ts_quality = q;
        return w;
    endfunction

    function automatic rtq_pkg::item_t noise_word();
        rtq_pkg::item_t w;
        w.operation = 2'($urandom_range(0, 3));
        w.range_cm = $urandom;
        w.block_index = $urandom;
        w.verdict_ok = 1'($urandom);
        w.ts_quality = 16'($urandom);
        return w;
    endfunction

    // Evidence mostly near the quality threshold, mostly with a good verdict.
    function automatic rtq_pkg::item_t evidence_word();
        rtq_pkg::item_t w;
        longint         q;
        w = noise_word();
        w.operation = rtq_pkg::OP_EVIDENCE;
        w.verdict_ok = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 4) != 0)
        begin
            q = longint'(cur_qthresh) + longint'($urandom_range(0, 300)) - 60;
            if (q > 32767)
            begin
                q = 32767;
            end
            if (q < -32768)
            begin
                q = -32768;
            end
            w.ts_quality = q[15:0];
        end
        return w;
    endfunction

    // A range near the last one, or with wild set an implausible, boundary or random one.
    function automatic rtq_pkg::item_t range_word(bit wild);
        rtq_pkg::item_t w;
        longint         lo;
        longint         hi;
        longint         v;
        int             lim;
        lo = -longint'(cur_neg_tol);
        hi = longint'(cur_max_cm);
        w = noise_word();
        w.operation = rtq_pkg::OP_RANGE;
        if (!wild)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                near_cm = longint'($urandom_range(0, cur_max_cm));
            end
            lim = int'(cur_spread) + (($urandom_range(0, 4) == 0) ? 3 : 0);
            v = near_cm + longint'($urandom_range(0, 2 * lim)) - lim;
            if (v < lo)
            begin
                v = lo;
            end
            if (v > hi)
            begin
                v = hi;
            end
            near_cm = (v < 0) ? 0 : v;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: v = lo - 1 - longint'($urandom_range(0, 1000));
                1:
                begin
                    if (hi < 2147483647)
                    begin
                        v = hi + 1 + longint'($urandom_range(0, 1000));
                        if (v > 2147483647)
                        begin
                            v = 2147483647;
                        end
                    end
                    else
                    begin
                        v = lo - 1;
                    end
                end
                2:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        v = lo - longint'($urandom_range(0, 1));
                    end
                    else
                    begin
                        v = hi + longint'($urandom_range(0, 1));
                    end
                end
                default: v = $signed($urandom);
            endcase
        end
        w.range_cm = v[31:0];
        return w;
    endfunction

    // Offer one event word and return at the edge where it is taken.
    task automatic send_word(rtq_pkg::item_t w);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.operation <= w.operation;
        evt_ch.range_cm <= w.range_cm;
        evt_ch.block_index <= w.block_index;
        evt_ch.verdict_ok <= w.verdict_ok;
        evt_ch.ts_quality <= w.ts_quality;
        do @(posedge clk); while (!evt_ch.ready);
    endtask

    // Stop offering and wait until every predicted result word has come back.
    task automatic settle_results();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0) @(posedge clk);
    endtask

    // One register write; psel stays high so writes can follow back to back.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apply_config(logic [15:0] neg, logic [30:0] mx, logic [15:0] spr,
                                logic [7:0] win, logic signed [15:0] qt);
        settle_results();
        write_reg(rtq_pkg::REG_NEG_TOL, {16'd0, neg});
        write_reg(rtq_pkg::REG_MAX_CM, {1'b0, mx});
        write_reg(rtq_pkg::REG_SPREAD, {16'd0, spr});
        write_reg(rtq_pkg::REG_WINDOW, {24'd0, win});
        write_reg(rtq_pkg::REG_QTHRESH, {16'd0, qt});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_neg_tol = neg;
        cur_max_cm = mx;
        cur_spread = spr;
        cur_qthresh = qt;
    endtask

    // Mostly evidence-then-range pairs; wild_pct percent are noise, resets and odd ranges.
    task automatic random_traffic(int count, int ev_pct, int wild_pct);
        rtq_pkg::item_t w;
        int             sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < wild_pct)
            begin
                case ($urandom_range(0, 2))
                    0: w = noise_word();
                    1:
                    begin
                        w = noise_word();
                        w.operation = rtq_pkg::OP_RESET;
                    end
                    default: w = range_word(1'b1);
                endcase
                send_word(w);
                if (w.operation != OP_UNUSED)
                begin
                    sent++;
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < ev_pct)
                begin
                    send_word(evidence_word());
                    sent++;
                end
                send_word(range_word(1'b0));
                sent++;
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off when requested.
    initial
    begin : result_side
        int stall;
        int take_calm;
        take_calm = 0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                stall = LONG_HOLD;
                long_hold = 1'b0;
            end
            else
            begin
                stall = draw_wait(take_calm);
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        evt_ch.valid = 1'b0;
        evt_ch.operation = rtq_pkg::OP_EVIDENCE;
        evt_ch.range_cm = '0;
        evt_ch.block_index = '0;
        evt_ch.verdict_ok = 1'b0;
        evt_ch.ts_quality = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings: tolerance 50, max 3000, spread 30,
        // window 3, threshold 0.
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd100, 32'd0, 1'b1, 16'sd0));      // no evidence
        send_word(mk(OP_UNUSED, 32'sd7, 32'd7, 1'b1, 16'sd7));
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'hFFFF_FFFF, 1'b1, 16'sh7FFF));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd110, 32'hFFFF_FFFF, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sd0));      // at threshold
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd140, 32'd1, 1'b0, 16'sd0));      // step == spread
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sd5));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd171, 32'd2, 1'b0, 16'sd0));      // past spread
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b0, 16'sd100));    // bad verdict
        send_word(mk(rtq_pkg::OP_RANGE, -32'sd50, 32'd3, 1'b0, 16'sd0));      // clamps to zero
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sh8000));   // below threshold
        send_word(mk(rtq_pkg::OP_RANGE, -32'sd51, 32'd4, 1'b0, 16'sd0));      // implausible
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd3000, 32'd5, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd3001, 32'd6, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sh8000_0000, 32'd8, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sh7FFF_FFFF, 32'd9, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_RESET, 32'sd0, 32'd0, 1'b0, 16'sd0));
        // A good-evidence run long enough to reach the window.
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sd200));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd0, 32'd10, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sd50));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd10, 32'd11, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sd300));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd20, 32'd12, 1'b0, 16'sd0));
        // A range reset drops evidence that is still pending.
        send_word(mk(rtq_pkg::OP_EVIDENCE, 32'sd0, 32'd0, 1'b1, 16'sd7));
        send_word(mk(rtq_pkg::OP_RESET, 32'sd0, 32'd0, 1'b0, 16'sd0));
        send_word(mk(rtq_pkg::OP_RANGE, 32'sd30, 32'd13, 1'b0, 16'sd0));

        // Reset settings written back; the result side holds off while words keep coming.
        apply_config(16'd50, 31'd3000, 16'd30, 8'd3, 16'sd0);
        long_hold = 1'b1;
        send_calm = 60;
        random_traffic(220, 70, 25);

        // Widest settings, long agreeing runs to saturate a full window.
        apply_config(16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 8'd255, 16'sh8000);
        random_traffic(380, 20, 0);

        // Narrowest settings: only zero is plausible.
        apply_config(16'd0, 31'd0, 16'd0, 8'd1, 16'sh7FFF);
        random_traffic(140, 50, 30);

        // Trust window zero: runs never grow past one and both flags read set.
        apply_config(16'd100, 31'd5000, 16'd40, 8'd0, 16'sd100);
        random_traffic(140, 60, 25);

        repeat (3)
        begin
            apply_config(16'($urandom_range(0, 200)), 31'($urandom_range(0, 6000)),
                         16'($urandom_range(0, 60)), 8'($urandom_range(1, 8)),
                         16'(int'($urandom_range(0, 600)) - 300));
            random_traffic(120, 60, 20);
        end

        settle_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
